### rtl/core/str_pkg.sv
package str_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int MASK_W     = 8;
    localparam int TIME_W     = 32;
    localparam int FREQ_W     = 18;
    localparam int RADIAL_W   = 15;
    localparam int STRENGTH_W = 16;
    localparam int AGE_CFG_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 1'd1;

    // Command codes
    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [AGE_CFG_W-1:0]  MAX_AGE_RESET   = 16'd10;
    localparam logic [STRENGTH_W-1:0] THRESHOLD_RESET = 16'd0;

    typedef struct packed {
        logic                         command;
        logic [FREQ_W-1:0]            freq;
        logic [RADIAL_W-1:0]          radial;
        logic signed [STRENGTH_W-1:0] strength;
    } t_str_req;

    typedef struct packed {
        logic [2:0]        slot;
        logic              written;
        logic [3:0]        purged_count;
        logic [MASK_W-1:0] valid_mask;
    } t_str_rsp;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } t_str_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_str_sts;

endpackage

### rtl/core/str_ctrl.sv
module str_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  str_pkg::t_str_sts i_sts,
    output str_pkg::t_str_cmd o_cmd,
    output logic              o_in_stall
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### rtl/core/str_dp.sv
module str_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  str_pkg::t_str_req                   i_in_req,
    input  str_pkg::t_str_cmd                   i_cmd,
    output str_pkg::t_str_sts                   o_sts,
    input  logic                                i_cfg_valid,
    input  logic [str_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [str_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output str_pkg::t_str_rsp                   o_out_rsp
);

    localparam int N  = str_pkg::NUM_SLOTS;
    localparam int IW = str_pkg::IDX_W;
    localparam int CW = str_pkg::CNT_W;
    localparam int TW = str_pkg::TIME_W;

    // configuration
    logic signed [str_pkg::STRENGTH_W-1:0] r_threshold;
    logic [str_pkg::AGE_CFG_W-1:0]         r_max_age;

    // table
    logic [N-1:0]                      r_valid;
    logic [str_pkg::FREQ_W-1:0]        r_freq     [N];
    logic [str_pkg::RADIAL_W-1:0]      r_radial   [N];
    logic [str_pkg::STRENGTH_W-1:0]    r_strength [N];
    logic [TW-1:0]                     r_time     [N];
    logic [TW-1:0]                     r_cur_time;

    // current request
    logic                              r_do_write;
    logic [str_pkg::FREQ_W-1:0]        r_req_freq;
    logic [str_pkg::RADIAL_W-1:0]      r_req_radial;
    logic [str_pkg::STRENGTH_W-1:0]    r_req_strength;

    // scan state
    logic [IW-1:0]                     r_idx;
    logic                              r_match_hit;
    logic [IW-1:0]                     r_match_idx;
    logic                              r_inv_hit;
    logic [IW-1:0]                     r_inv_idx;
    logic [IW-1:0]                     r_old_idx;
    logic [TW-1:0]                     r_old_age;
    logic [N-1:0]                      r_purge;
    logic [CW-1:0]                     r_purge_cnt;

    // output register
    logic                              r_out_valid;
    str_pkg::t_str_rsp                 r_out_rsp;

    logic [TW-1:0]                     w_age;
    logic [IW-1:0]                     n_sel;
    logic [N-1:0]                      n_valid;
    logic [CW-1:0]                     n_cnt;
    logic [str_pkg::MASK_W-1:0]        n_mask;

    assign w_age = r_cur_time - r_time[r_idx];

    always_comb begin
        if (r_match_hit) begin
            n_sel = r_match_idx;
        end else if (r_inv_hit) begin
            n_sel = r_inv_idx;
        end else begin
            n_sel = r_old_idx;
        end
    end

    // A freshly written slot has age zero, so it is never purged.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_valid[i] = (r_valid[i] & ~r_purge[i]) | (r_do_write && (n_sel == IW'(i)));
        end
        n_mask = '0;
        for (int i = 0; i < str_pkg::MASK_W; i++) begin
            if (i < N) begin
                n_mask[i] = n_valid[IW'(i)];
            end
        end
        n_cnt = r_purge_cnt - CW'(r_do_write && r_purge[n_sel]);
    end

    assign o_sts.scan_last = (r_idx == IW'(N - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= str_pkg::THRESHOLD_RESET;
            r_max_age   <= str_pkg::MAX_AGE_RESET;
            r_valid     <= '0;
            r_cur_time  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    str_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    str_pkg::CFG_MAX_AGE:   r_max_age   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start && (i_in_req.command == str_pkg::CMD_TICK)) begin
                r_cur_time <= r_cur_time + TW'(1);
            end
            if (i_cmd.commit) begin
                r_valid     <= n_valid;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table contents (reset to zero per entry)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_freq[i]     <= '0;
                r_radial[i]   <= '0;
                r_strength[i] <= '0;
                r_time[i]     <= '0;
            end
        end else if (i_cmd.commit && r_do_write) begin
            r_freq[n_sel]     <= r_req_freq;
            r_radial[n_sel]   <= r_req_radial;
            r_strength[n_sel] <= r_req_strength;
            r_time[n_sel]     <= r_cur_time;
        end
    end

    // request capture and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_do_write     <= (i_in_req.command == str_pkg::CMD_REPORT)
                              && (i_in_req.strength > r_threshold);
            r_req_freq     <= i_in_req.freq;
            r_req_radial   <= i_in_req.radial;
            r_req_strength <= i_in_req.strength;
            r_idx          <= '0;
            r_match_hit    <= 1'b0;
            r_match_idx    <= '0;
            r_inv_hit      <= 1'b0;
            r_inv_idx      <= '0;
            r_old_idx      <= '0;
            r_old_age      <= '0;
            r_purge        <= '0;
            r_purge_cnt    <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IW'(1);
            // later hits overwrite earlier ones: highest index wins
            if (r_freq[r_idx] == r_req_freq) begin
                r_match_hit <= 1'b1;
                r_match_idx <= r_idx;
            end
            if (!r_valid[r_idx]) begin
                r_inv_hit <= 1'b1;
                r_inv_idx <= r_idx;
            end
            // strict compare keeps the lowest index on ties
            if (w_age > r_old_age) begin
                r_old_age <= w_age;
                r_old_idx <= r_idx;
            end
            if (w_age > TW'(r_max_age)) begin
                r_purge[r_idx] <= 1'b1;
                r_purge_cnt    <= r_purge_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_rsp.slot         <= r_do_write ? 3'(n_sel) : 3'd0;
            r_out_rsp.written      <= r_do_write;
            r_out_rsp.purged_count <= 4'(n_cnt);
            r_out_rsp.valid_mask   <= n_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

### rtl/core/station_table_replacement.sv
// Beacon station table with match / invalid / oldest slot replacement.
//
// Request channel (i_in_valid / o_in_stall / i_in_req): a request is taken at
// a rising edge with i_in_valid high and o_in_stall low. A tick request
// advances the seconds counter; a report request with strength strictly above
// the strength threshold is stored in a slot chosen as: highest-index slot with
// the same frequency, else highest-index invalid slot, else the oldest slot
// (lowest index on ties). After every request, slots older than max_age drop.
// Result channel (o_out_valid / i_out_stall / o_out_rsp): one result for each
// request, taken at an edge with o_out_valid high and i_out_stall low.
// Configuration (i_cfg_valid / o_cfg_ready): always ready; index 0 writes
// the strength threshold, index 1 writes max_age.
// Timing: the controller walks the table one slot per cycle. After the scan, a
// request's result is committed to the output register, and no new request is
// taken until that commit. A stalled result waits in the output register while
// the next request is accepted and scanned; the new result is loaded once the
// old one is taken. Reset clears all slots, the time counter, and loads a
// strength threshold of 0 and max_age = 10.
module station_table_replacement (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  str_pkg::t_str_req              i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output str_pkg::t_str_rsp              o_out_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [str_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [str_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    str_pkg::t_str_cmd w_cmd;
    str_pkg::t_str_sts w_sts;

    // Config writes land directly in registers; never hold them off.
    assign o_cfg_ready = 1'b1;

    // Sequence the scan: idle, a scan step for each slot, then commit once the output register is free.
    str_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold the table, scan registers and output register.
    str_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // An accepted request always puts the block to work.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a request");

    // A new result only appears after a request was in progress.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

    // A result that stored nothing reports slot zero.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.written) |-> (o_out_rsp.slot == 3'd0))
        else $error("nonzero slot on a result that stored nothing");

    // The slot just written is valid in the reported mask.
    a_written_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.written && (str_pkg::NUM_SLOTS <= 8))
            |-> o_out_rsp.valid_mask[o_out_rsp.slot])
        else $error("written slot not shown valid");

endmodule

### tb/station_table_replacement_test.sv
module station_table_replacement_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS  = str_pkg::NUM_SLOTS;
    localparam int FREQ_W     = str_pkg::FREQ_W;
    localparam int RADIAL_W   = str_pkg::RADIAL_W;
    localparam int STRENGTH_W = str_pkg::STRENGTH_W;
    localparam int AGE_CFG_W  = str_pkg::AGE_CFG_W;
    localparam int TIME_W     = str_pkg::TIME_W;
    localparam int MASK_W     = str_pkg::MASK_W;
    localparam int CFG_IDX_W  = str_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = str_pkg::CFG_DATA_W;

    localparam logic CMD_REPORT = str_pkg::CMD_REPORT;
    localparam logic CMD_TICK   = str_pkg::CMD_TICK;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = str_pkg::CFG_THRESHOLD;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = str_pkg::CFG_MAX_AGE;

    // Cycles with no request, result or register write accepted before the run is abandoned.
    // Requests scan all slots one at a time, plus short sender gaps and random result stalls.
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 2 * (NUM_SLOTS + 2);
    localparam int NUM_ROWS     = 20;
    localparam int NUM_PHASES   = 6;
    localparam int FREQ_POOL    = 12;

    // One row of the directed table: a request, how many times to send it, and
    // an optional hand-typed result that replaces the predicted one.
    typedef struct packed {
        str_pkg::t_str_req req;
        int                reps;
        bit                typed;
        str_pkg::t_str_rsp rsp;
    } t_dir_row;

    // One random phase: register settings and the idle/stall mix on each side.
    typedef struct packed {
        int                       items;
        logic [STRENGTH_W-1:0]    min_str;
        logic [AGE_CFG_W-1:0]     max_age;
        int                       idle_pct;
        int                       stall_pct;
        bit                       hold_mid;
    } t_phase;

    // Directed rows run from reset with a strength threshold of 0 and max_age = 10.
    localparam t_dir_row DIR_ROWS [NUM_ROWS] = '{
        // strength equal to the threshold: rejected, nothing stored
        '{'{CMD_REPORT, 18'd0,      15'd0,     16'h0000}, 1, 1'b1, '{3'd0, 1'b0, 4'd0, 8'h00}},
        // all-ones fields into an empty table: highest invalid slot
        '{'{CMD_REPORT, 18'h3FFFF,  15'h7FFF,  16'h7FFF}, 1, 1'b1, '{3'd7, 1'b1, 4'd0, 8'h80}},
        // frequency 0 matches the never-written slots, valid or not: highest one wins
        '{'{CMD_REPORT, 18'd0,      15'd0,     16'h0001}, 1, 1'b1, '{3'd6, 1'b1, 4'd0, 8'hC0}},
        // most negative strength: rejected
        '{'{CMD_REPORT, 18'd5000,   15'd100,   16'h8000}, 1, 1'b1, '{3'd0, 1'b0, 4'd0, 8'hC0}},
        // fill the rest of the table at time zero
        '{'{CMD_REPORT, 18'd108000, 15'd23039, 16'h0100}, 1, 1'b1, '{3'd5, 1'b1, 4'd0, 8'hE0}},
        '{'{CMD_REPORT, 18'd109000, 15'd0,     16'h0100}, 1, 1'b1, '{3'd4, 1'b1, 4'd0, 8'hF0}},
        '{'{CMD_REPORT, 18'd110000, 15'd1,     16'h0100}, 1, 1'b1, '{3'd3, 1'b1, 4'd0, 8'hF8}},
        '{'{CMD_REPORT, 18'd111000, 15'd2,     16'h0100}, 1, 1'b1, '{3'd2, 1'b1, 4'd0, 8'hFC}},
        '{'{CMD_REPORT, 18'd112000, 15'd3,     16'h0100}, 1, 1'b1, '{3'd1, 1'b1, 4'd0, 8'hFE}},
        '{'{CMD_REPORT, 18'd113000, 15'd4,     16'h0100}, 1, 1'b1, '{3'd0, 1'b1, 4'd0, 8'hFF}},
        // full table, no match, every slot equally old: lowest index
        '{'{CMD_REPORT, 18'd114000, 15'd1,     16'h0200}, 1, 1'b1, '{3'd0, 1'b1, 4'd0, 8'hFF}},
        '{'{CMD_TICK,   18'd0,      15'd0,     16'h0000}, 1, 1'b1, '{3'd0, 1'b0, 4'd0, 8'hFF}},
        // frequency already held by a valid slot
        '{'{CMD_REPORT, 18'd108000, 15'd5,     16'h0300}, 1, 1'b1, '{3'd5, 1'b1, 4'd0, 8'hFF}},
        // full table, no match: oldest slot, ties to the lowest index
        '{'{CMD_REPORT, 18'd115000, 15'd6,     16'h0100}, 1, 1'b0, '0},
        // age the table past max_age: partial purge, then everything counted
        '{'{CMD_TICK,   18'd0,      15'd0,     16'h0000}, 10, 1'b0, '0},
        '{'{CMD_TICK,   18'h3FFFF,  15'h7FFF,  16'hFFFF}, 1, 1'b1, '{3'd0, 1'b0, 4'd8, 8'h00}},
        // frequency match against a purged slot
        '{'{CMD_REPORT, 18'h3FFFF,  15'd0,     16'h7FFF}, 1, 1'b0, '0},
        '{'{CMD_REPORT, 18'd0,      15'd7,     16'hFFFF}, 1, 1'b0, '0},
        '{'{CMD_REPORT, 18'd0,      15'h7FFF,  16'h0001}, 1, 1'b0, '0},
        '{'{CMD_TICK,   18'd0,      15'd0,     16'h0000}, 1, 1'b0, '0}
    };

    localparam t_phase PHASES [NUM_PHASES] = '{
        '{300, 16'h0000, 16'd10,   0,  0,  1'b0},
        '{250, 16'h8000, 16'd0,    50, 0,  1'b0},
        '{100, 16'h7FFF, 16'hFFFF, 0,  50, 1'b0},
        '{300, 16'h0100, 16'd3,    10, 10, 1'b1},
        '{300, 16'hFE00, 16'd20,   0,  50, 1'b0},
        '{300, 16'h0000, 16'hFFFF, 50, 0,  1'b0}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    str_pkg::t_str_req     in_req      = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    str_pkg::t_str_rsp     out_rsp;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // Predicted table contents and registers, mirrored at each accepted request.
    logic                         st_valid    [NUM_SLOTS] = '{default: 1'b0};
    logic [FREQ_W-1:0]            st_freq     [NUM_SLOTS] = '{default: '0};
    logic [RADIAL_W-1:0]          st_radial   [NUM_SLOTS] = '{default: '0};
    logic [STRENGTH_W-1:0]        st_strength [NUM_SLOTS] = '{default: '0};
    logic [TIME_W-1:0]            st_stamp    [NUM_SLOTS] = '{default: '0};
    logic [TIME_W-1:0]            now_sec     = '0;
    logic signed [STRENGTH_W-1:0] cfg_min_str = str_pkg::THRESHOLD_RESET;
    logic [AGE_CFG_W-1:0]         cfg_max_age = str_pkg::MAX_AGE_RESET;

    str_pkg::t_str_rsp rsp_due_q [$];
    int       mismatch_cnt = 0;
    int       quiet_cycles = 0;
    int       tx_idle_pct  = 0;
    int       rx_stall_pct = 0;

    station_table_replacement u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the mirrored table by one request and return the result it causes.
    function automatic str_pkg::t_str_rsp apply_station_item(input str_pkg::t_str_req req);
        str_pkg::t_str_rsp rsp;
        int                hit;
        int                spare;
        int                eldest;
        int                pick;
        int                purged;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] eldest_age;
        rsp    = '0;
        purged = 0;
        if (req.command == CMD_TICK) begin
            now_sec = now_sec + 1'b1;
        end else if ($signed(req.strength) > $signed(cfg_min_str)) begin
            hit        = -1;
            spare      = -1;
            eldest     = 0;
            eldest_age = now_sec - st_stamp[0];
            // Frequency match looks at every slot, valid or not.
            for (int i = 0; i < NUM_SLOTS; i++) begin
                age = now_sec - st_stamp[i];
                if (st_freq[i] == req.freq) hit = i;
                if (!st_valid[i]) spare = i;
                if (age > eldest_age) begin
                    eldest_age = age;
                    eldest     = i;
                end
            end
            pick = (hit >= 0) ? hit : (spare >= 0) ? spare : eldest;
            st_freq[pick]     = req.freq;
            st_radial[pick]   = req.radial;
            st_strength[pick] = req.strength;
            st_stamp[pick]    = now_sec;
            st_valid[pick]    = 1'b1;
            rsp.slot          = pick[2:0];
            rsp.written       = 1'b1;
        end
        // Drop and count every stale slot, whether or not it was valid.
        for (int i = 0; i < NUM_SLOTS; i++) begin
            age = now_sec - st_stamp[i];
            if (age > TIME_W'(cfg_max_age)) begin
                st_valid[i] = 1'b0;
                purged++;
            end
        end
        rsp.purged_count = 4'(purged);
        for (int i = 0; i < NUM_SLOTS && i < MASK_W; i++) begin
            rsp.valid_mask[i] = st_valid[i];
        end
        return rsp;
    endfunction

    // Mostly reports on a small set of frequencies so that matches, full tables and
    // oldest-slot choices come up often; strength hugs the threshold half the time.
    function automatic str_pkg::t_str_req random_station_request();
        str_pkg::t_str_req req;
        int                near;
        req.command  = ($urandom_range(0, 3) == 0) ? CMD_TICK : CMD_REPORT;
        req.freq     = ($urandom_range(0, 4) == 0) ? FREQ_W'($urandom_range(0, 262143))
                     : FREQ_W'(100000 + 1000 * $urandom_range(0, FREQ_POOL - 1));
        req.radial   = ($urandom_range(0, 9) == 0) ? RADIAL_W'($urandom_range(0, 32767))
                     : RADIAL_W'($urandom_range(0, 23039));
        if ($urandom_range(0, 1) == 0) begin
            req.strength = STRENGTH_W'($urandom());
        end else begin
            near = int'(cfg_min_str) + int'($urandom_range(0, 40)) - 8;
            if (near > 32767) near = 32767;
            if (near < -32768) near = -32768;
            req.strength = STRENGTH_W'(near);
        end
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Present one request, hold it until taken, then record what it should produce.
    task automatic send_request(input str_pkg::t_str_req req, input bit typed,
                                input str_pkg::t_str_rsp typed_rsp);
        str_pkg::t_str_rsp due;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        due = apply_station_item(req);
        rsp_due_q = {rsp_due_q, (typed ? typed_rsp : due)};
    endtask

    // Drop valid and hold off until every outstanding result has been taken.
    task automatic pause_sender();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rsp_due_q.size() != 0) @(posedge clk);
    endtask

    // Write both registers back to back, keeping valid high between them.
    task automatic write_registers(input logic [STRENGTH_W-1:0] min_str,
                                   input logic [AGE_CFG_W-1:0] max_age);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= min_str;
        do @(posedge clk); while (!cfg_ready);
        cfg_min_str = min_str;
        cfg_index <= CFG_MAX_AGE;
        cfg_data  <= max_age;
        do @(posedge clk); while (!cfg_ready);
        cfg_max_age = max_age;
        cfg_valid <= 1'b0;
    endtask

    // Result side: compare each taken result with the oldest one due, then pick
    // the stall for the next cycle.
    always @(posedge clk) begin
        str_pkg::t_str_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            if (rsp_due_q.size() == 0) begin
                report_mismatch("unexpected result", 32'(out_rsp), 32'h0);
            end else begin
                want = rsp_due_q.pop_front();
                if (out_rsp.slot !== want.slot)
                    report_mismatch("slot", 32'(out_rsp.slot), 32'(want.slot));
                if (out_rsp.written !== want.written)
                    report_mismatch("written", 32'(out_rsp.written), 32'(want.written));
                if (out_rsp.purged_count !== want.purged_count)
                    report_mismatch("purged_count", 32'(out_rsp.purged_count),
                                    32'(want.purged_count));
                if (out_rsp.valid_mask !== want.valid_mask)
                    report_mismatch("valid_mask", 32'(out_rsp.valid_mask),
                                    32'(want.valid_mask));
            end
        end
        out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Watchdog: any accepted request, result or register write resets the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, registers still at their reset values.
        foreach (DIR_ROWS[r]) begin
            repeat (DIR_ROWS[r].reps) begin
                send_request(DIR_ROWS[r].req, DIR_ROWS[r].typed, DIR_ROWS[r].rsp);
            end
        end
        pause_sender();

        // Random phases; registers change only once the block has drained.
        foreach (PHASES[p]) begin
            rx_stall_pct = PHASES[p].stall_pct;
            tx_idle_pct  = PHASES[p].idle_pct;
            write_registers(PHASES[p].min_str, PHASES[p].max_age);
            for (int n = 0; n < PHASES[p].items; n++) begin
                if (PHASES[p].hold_mid && n == PHASES[p].items / 2) pause_sender();
                send_request(random_station_request(), 1'b0, '0);
            end
            pause_sender();
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && rsp_due_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
